// ----- rtl/qqwm_pkg.sv -----
// Shared types, constants and a helper function for the queue quota watermark monitor.
package qqwm_pkg;

    localparam int AGE_BITS  = 16;
    localparam int FRAC_BITS = 16;
    localparam int AVG_W     = 24 + FRAC_BITS;
    localparam int HALF_W    = (AVG_W + 1) / 2;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int PROD_W    = AVG_W + Q_W;

    localparam logic [23:0] CNT24_MAX = 24'hFF_FFFF;
    localparam logic [39:0] RATE_MAX  = 40'hFF_FFFF_FFFF;
    localparam logic [Q_W-1:0] ONE_Q  = Q_W'(1) << FRAC_BITS;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_ENQUEUE = 2'd1;
    localparam logic [1:0] REQ_DEQUEUE = 2'd2;

    localparam logic CFG_ALERT_THRESHOLD = 1'b0;
    localparam logic CFG_SAMPLE_WEIGHT   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_POW,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_WB,
        ST_SUM,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        M_RES,
        M_SQR,
        M_AVG,
        M_WIE,
        M_RATE
    } mop_t;

    typedef enum logic [1:0] {
        PH_ACCRUE,
        PH_BLEND,
        PH_RATE
    } phase_t;

    typedef struct packed {
        logic load;
        logic accum;
    } mac_ctl_t;

    // Ages beyond the power loop's reach are clamped to the largest exponent.
    function automatic logic [AGE_BITS-1:0] clamp_age(input logic [31:0] age);
        logic [63:0] wide;
        wide = 64'(age);
        if (wide > ((64'd1 << AGE_BITS) - 64'd1)) begin
            clamp_age = '1;
        end else begin
            clamp_age = wide[AGE_BITS-1:0];
        end
    endfunction

endpackage

// ----- rtl/qqwm_mac.sv -----
// Shared multiplier that builds one wide product from two half-width partial products.
module qqwm_mac (
    input  logic                               aclk,
    input  qqwm_pkg::mac_ctl_t                 ctl,
    input  logic [qqwm_pkg::HALF_W-1:0]        a_part,
    input  logic [qqwm_pkg::Q_W-1:0]           b,
    output logic [qqwm_pkg::PROD_W-1:0]        acc
);

    logic [qqwm_pkg::HALF_W+qqwm_pkg::Q_W-1:0] prod;
    logic [qqwm_pkg::PROD_W-1:0]               acc_reg;
    logic [qqwm_pkg::PROD_W-1:0]               acc_next;

    assign prod = {{qqwm_pkg::Q_W{1'b0}}, a_part} * {{qqwm_pkg::HALF_W{1'b0}}, b};

    always_comb begin
        acc_next = acc_reg;
        if (ctl.load) begin
            acc_next = qqwm_pkg::PROD_W'(prod);
        end else if (ctl.accum) begin
            acc_next = acc_reg + (qqwm_pkg::PROD_W'(prod) << qqwm_pkg::HALF_W);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ----- rtl/queue_quota_watermark_monitor.sv -----
// Top level of the queue quota watermark monitor.
//
// One request enters on the s_ channel (valid/ready) and produces exactly one
// result on the m_ channel (valid/ready). The user must write configuration
// through cfg_wr_en/cfg_addr/cfg_wdata only while the block is idle; the block
// itself does not enforce this. A request that needs no decay power passes
// through the exec, check and finish states. A write that opens a new
// interval, and every request that sets a new high-water mark, runs
// square-and-multiply powers over a 16-bit age on the one shared multiplier,
// whose multiplies each pass through a low-half, a high-half and a write-back
// state. The worst request, a write that opens a new interval and sets a new
// high-water mark, runs three such powers.
// s_ready is high only in the idle state. A finished result sits in the
// output register until taken; the next request may be accepted and worked on
// meanwhile, and it waits at its end until the output register is free.
// Reset (aresetn low at a clock edge) clears all counters, the average, the
// high-water mark and the alert flag, restores the register defaults, and
// drops m_valid.
module queue_quota_watermark_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [23:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [15:0] s_msg_count,
    input  logic        s_pipe_attached,
    input  logic [23:0] s_pipe_unread,
    input  logic [31:0] s_interval_now,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_total_used,
    output logic        m_new_max,
    output logic        m_alert,
    output logic [23:0] m_max_used,
    output logic [39:0] m_rate_average,
    output logic [31:0] m_writes_seen,
    output logic [31:0] m_enqueued_seen,
    output logic [31:0] m_dequeued_seen
);

    localparam int AGE_BITS  = qqwm_pkg::AGE_BITS;
    localparam int FRAC_BITS = qqwm_pkg::FRAC_BITS;
    localparam int AVG_W     = qqwm_pkg::AVG_W;
    localparam int HALF_W    = qqwm_pkg::HALF_W;
    localparam int Q_W       = qqwm_pkg::Q_W;
    localparam int PROD_W    = qqwm_pkg::PROD_W;

    qqwm_pkg::state_t state_reg, state_next;
    qqwm_pkg::mop_t   mop_reg, mop_next;
    qqwm_pkg::phase_t phase_reg, phase_next;

    logic [AGE_BITS-1:0] pow_age_reg, pow_age_next;
    logic [Q_W-1:0]      res_reg, res_next;
    logic [Q_W-1:0]      base_reg, base_next;
    logic [AVG_W-1:0]    term_reg, term_next;
    logic [AVG_W-1:0]    blend_reg, blend_next;
    logic [39:0]         rate_reg, rate_next;
    logic                new_max_reg, new_max_next;
    logic                raise_reg, raise_next;
    logic [23:0]         total_reg, total_next;

    logic [1:0]  req_reg, req_next;
    logic [15:0] num_reg, num_next;
    logic        att_reg, att_next;
    logic [23:0] unread_reg, unread_next;
    logic [31:0] now_reg, now_next;

    logic [23:0]      local_queued_reg, local_queued_next;
    logic [23:0]      high_water_reg, high_water_next;
    logic             alert_done_reg, alert_done_next;
    logic [31:0]      interval_events_reg, interval_events_next;
    logic [31:0]      events_interval_reg, events_interval_next;
    logic [31:0]      average_age_reg, average_age_next;
    logic [AVG_W-1:0] decayed_avg_reg, decayed_avg_next;
    logic [31:0]      write_total_reg, write_total_next;
    logic [31:0]      enqueue_total_reg, enqueue_total_next;
    logic [31:0]      dequeue_total_reg, dequeue_total_next;

    logic [23:0] alert_threshold_reg, alert_threshold_next;
    logic [15:0] sample_weight_reg, sample_weight_next;

    logic        m_valid_reg, m_valid_next;
    logic [23:0] m_total_used_reg, m_total_used_next;
    logic        m_new_max_reg, m_new_max_next;
    logic        m_alert_reg, m_alert_next;
    logic [23:0] m_max_used_reg, m_max_used_next;
    logic [39:0] m_rate_average_reg, m_rate_average_next;
    logic [31:0] m_writes_seen_reg, m_writes_seen_next;
    logic [31:0] m_enqueued_seen_reg, m_enqueued_seen_next;
    logic [31:0] m_dequeued_seen_reg, m_dequeued_seen_next;

    qqwm_pkg::mac_ctl_t mac_ctl;
    logic [AVG_W-1:0]   mul_a;
    logic [Q_W-1:0]     mul_b;
    logic [HALF_W-1:0]  mul_a_part;
    logic [PROD_W-1:0]  mul_acc;
    logic [AVG_W:0]     mul_q;

    logic [16+FRAC_BITS:0] decay_ext;
    logic [15+FRAC_BITS:0] weight_ext;
    logic [Q_W-1:0]        decay_q;
    logic [FRAC_BITS-1:0]  weight_q;

    logic [PROD_W:0]  blend_sum;
    logic [AVG_W-1:0] blend_val;
    logic [63:0]      q_wide;
    logic [39:0]      rate_val;
    logic [31:0]      gap;
    logic [24:0]      local_sum;
    logic [25:0]      total_raw;
    logic [23:0]      total_sat;

    // Decay base d = 1 - w and the weight w, both brought to FRAC_BITS fraction bits.
    assign decay_ext  = {(17'h10000 - {1'b0, sample_weight_reg}), {FRAC_BITS{1'b0}}};
    assign decay_q    = decay_ext[16+FRAC_BITS:16];
    assign weight_ext = {sample_weight_reg, {FRAC_BITS{1'b0}}};
    assign weight_q   = weight_ext[15+FRAC_BITS:16];

    always_comb begin
        case (mop_reg)
            qqwm_pkg::M_RES: begin
                mul_a = AVG_W'(res_reg);
                mul_b = base_reg;
            end
            qqwm_pkg::M_SQR: begin
                mul_a = AVG_W'(base_reg);
                mul_b = base_reg;
            end
            qqwm_pkg::M_AVG: begin
                mul_a = decayed_avg_reg;
                mul_b = res_reg;
            end
            qqwm_pkg::M_WIE: begin
                mul_a = AVG_W'(interval_events_reg);
                mul_b = Q_W'(weight_q);
            end
            qqwm_pkg::M_RATE: begin
                mul_a = blend_reg;
                mul_b = res_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_a_part    = (state_reg == qqwm_pkg::ST_MUL_HI)
                         ? HALF_W'(mul_a[AVG_W-1:HALF_W]) : mul_a[HALF_W-1:0];
    assign mac_ctl.load  = (state_reg == qqwm_pkg::ST_MUL_LO);
    assign mac_ctl.accum = (state_reg == qqwm_pkg::ST_MUL_HI);

    qqwm_mac u_mac (
        .aclk   (aclk),
        .ctl    (mac_ctl),
        .a_part (mul_a_part),
        .b      (mul_b),
        .acc    (mul_acc)
    );

    assign mul_q    = mul_acc[PROD_W-1:FRAC_BITS];
    assign q_wide   = 64'(mul_q);
    assign rate_val = (q_wide > 64'(qqwm_pkg::RATE_MAX)) ? qqwm_pkg::RATE_MAX : q_wide[39:0];

    assign blend_sum = {1'b0, mul_acc} + (PROD_W+1)'(term_reg);
    assign blend_val = (blend_sum[PROD_W:AVG_W] != '0) ? '1 : blend_sum[AVG_W-1:0];
    assign gap       = (now_reg > events_interval_reg) ? (now_reg - events_interval_reg) : '0;

    assign local_sum = {1'b0, local_queued_reg} + 25'(num_reg);
    assign total_raw = 26'(local_queued_reg) + 26'(att_reg ? unread_reg : 24'd0)
                     + 26'(req_reg == qqwm_pkg::REQ_WRITE);
    assign total_sat = (total_raw > 26'(qqwm_pkg::CNT24_MAX)) ? qqwm_pkg::CNT24_MAX
                     : total_raw[23:0];

    always_comb begin
        state_next           = state_reg;
        mop_next             = mop_reg;
        phase_next           = phase_reg;
        pow_age_next         = pow_age_reg;
        res_next             = res_reg;
        base_next            = base_reg;
        term_next            = term_reg;
        blend_next           = blend_reg;
        rate_next            = rate_reg;
        new_max_next         = new_max_reg;
        raise_next           = raise_reg;
        total_next           = total_reg;
        req_next             = req_reg;
        num_next             = num_reg;
        att_next             = att_reg;
        unread_next          = unread_reg;
        now_next             = now_reg;
        local_queued_next    = local_queued_reg;
        high_water_next      = high_water_reg;
        alert_done_next      = alert_done_reg;
        interval_events_next = interval_events_reg;
        events_interval_next = events_interval_reg;
        average_age_next     = average_age_reg;
        decayed_avg_next     = decayed_avg_reg;
        write_total_next     = write_total_reg;
        enqueue_total_next   = enqueue_total_reg;
        dequeue_total_next   = dequeue_total_reg;
        alert_threshold_next = alert_threshold_reg;
        sample_weight_next   = sample_weight_reg;
        m_valid_next         = m_valid_reg && !m_ready;
        m_total_used_next    = m_total_used_reg;
        m_new_max_next       = m_new_max_reg;
        m_alert_next         = m_alert_reg;
        m_max_used_next      = m_max_used_reg;
        m_rate_average_next  = m_rate_average_reg;
        m_writes_seen_next   = m_writes_seen_reg;
        m_enqueued_seen_next = m_enqueued_seen_reg;
        m_dequeued_seen_next = m_dequeued_seen_reg;

        if (cfg_wr_en) begin
            case (cfg_addr)
                qqwm_pkg::CFG_ALERT_THRESHOLD: alert_threshold_next = cfg_wdata;
                qqwm_pkg::CFG_SAMPLE_WEIGHT:   sample_weight_next   = cfg_wdata[15:0];
                default: ;
            endcase
        end

        case (state_reg)
            qqwm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    req_next    = s_req_type;
                    num_next    = s_msg_count;
                    att_next    = s_pipe_attached;
                    unread_next = s_pipe_unread;
                    now_next    = s_interval_now;
                    state_next  = qqwm_pkg::ST_EXEC;
                end
            end
            qqwm_pkg::ST_EXEC: begin
                state_next = qqwm_pkg::ST_CHECK;
                case (req_reg)
                    qqwm_pkg::REQ_WRITE: begin
                        write_total_next = write_total_reg + 32'd1;
                        if (now_reg <= events_interval_reg) begin
                            if (interval_events_reg != '1) begin
                                interval_events_next = interval_events_reg + 32'd1;
                            end
                        end else begin
                            // A new interval folds the finished one into the average first.
                            phase_next   = qqwm_pkg::PH_ACCRUE;
                            pow_age_next = qqwm_pkg::clamp_age(average_age_reg);
                            res_next     = qqwm_pkg::ONE_Q;
                            base_next    = decay_q;
                            state_next   = qqwm_pkg::ST_POW;
                        end
                    end
                    qqwm_pkg::REQ_ENQUEUE: begin
                        enqueue_total_next = enqueue_total_reg + 32'(num_reg);
                        local_queued_next  = (local_sum > 25'(qqwm_pkg::CNT24_MAX))
                                           ? qqwm_pkg::CNT24_MAX : local_sum[23:0];
                    end
                    qqwm_pkg::REQ_DEQUEUE: begin
                        dequeue_total_next = dequeue_total_reg + 32'(num_reg);
                        local_queued_next  = (24'(num_reg) > local_queued_reg)
                                           ? 24'd0 : local_queued_reg - 24'(num_reg);
                    end
                    default: ;
                endcase
            end
            qqwm_pkg::ST_CHECK: begin
                total_next = total_sat;
                if ((req_reg == qqwm_pkg::REQ_WRITE || req_reg == qqwm_pkg::REQ_ENQUEUE)
                    && total_sat > high_water_reg) begin
                    high_water_next = total_sat;
                    new_max_next    = 1'b1;
                    raise_next      = (alert_threshold_reg != '0)
                                   && (total_sat >= alert_threshold_reg) && !alert_done_reg;
                    if (raise_next) begin
                        alert_done_next = 1'b1;
                    end
                    phase_next   = qqwm_pkg::PH_BLEND;
                    pow_age_next = qqwm_pkg::clamp_age(average_age_reg);
                    res_next     = qqwm_pkg::ONE_Q;
                    base_next    = decay_q;
                    state_next   = qqwm_pkg::ST_POW;
                end else begin
                    new_max_next = 1'b0;
                    raise_next   = 1'b0;
                    rate_next    = '0;
                    state_next   = qqwm_pkg::ST_FINISH;
                end
            end
            qqwm_pkg::ST_POW: begin
                state_next = qqwm_pkg::ST_MUL_LO;
                if (pow_age_reg == '0) begin
                    mop_next = (phase_reg == qqwm_pkg::PH_RATE) ? qqwm_pkg::M_RATE
                                                                 : qqwm_pkg::M_AVG;
                end else if (pow_age_reg[0]) begin
                    mop_next = qqwm_pkg::M_RES;
                end else begin
                    mop_next = qqwm_pkg::M_SQR;
                end
            end
            qqwm_pkg::ST_MUL_LO: begin
                state_next = qqwm_pkg::ST_MUL_HI;
            end
            qqwm_pkg::ST_MUL_HI: begin
                state_next = qqwm_pkg::ST_MUL_WB;
            end
            qqwm_pkg::ST_MUL_WB: begin
                case (mop_reg)
                    qqwm_pkg::M_RES: begin
                        res_next = mul_q[Q_W-1:0];
                        // The last set bit needs no further squaring of the base.
                        if (pow_age_reg[AGE_BITS-1:1] == '0) begin
                            pow_age_next = '0;
                            state_next   = qqwm_pkg::ST_POW;
                        end else begin
                            mop_next   = qqwm_pkg::M_SQR;
                            state_next = qqwm_pkg::ST_MUL_LO;
                        end
                    end
                    qqwm_pkg::M_SQR: begin
                        base_next    = mul_q[Q_W-1:0];
                        pow_age_next = pow_age_reg >> 1;
                        state_next   = qqwm_pkg::ST_POW;
                    end
                    qqwm_pkg::M_AVG: begin
                        term_next  = mul_q[AVG_W-1:0];
                        mop_next   = qqwm_pkg::M_WIE;
                        state_next = qqwm_pkg::ST_MUL_LO;
                    end
                    qqwm_pkg::M_WIE: begin
                        state_next = qqwm_pkg::ST_SUM;
                    end
                    qqwm_pkg::M_RATE: begin
                        rate_next  = rate_val;
                        state_next = qqwm_pkg::ST_FINISH;
                    end
                    default: begin
                        state_next = qqwm_pkg::ST_FINISH;
                    end
                endcase
            end
            qqwm_pkg::ST_SUM: begin
                if (phase_reg == qqwm_pkg::PH_ACCRUE) begin
                    decayed_avg_next     = blend_val;
                    average_age_next     = now_reg - events_interval_reg;
                    interval_events_next = 32'd1;
                    events_interval_next = now_reg;
                    state_next           = qqwm_pkg::ST_CHECK;
                end else begin
                    blend_next   = blend_val;
                    phase_next   = qqwm_pkg::PH_RATE;
                    pow_age_next = qqwm_pkg::clamp_age(gap);
                    res_next     = qqwm_pkg::ONE_Q;
                    base_next    = decay_q;
                    state_next   = qqwm_pkg::ST_POW;
                end
            end
            qqwm_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_total_used_next    = total_reg;
                    m_new_max_next       = new_max_reg;
                    m_alert_next         = raise_reg;
                    m_max_used_next      = high_water_reg;
                    m_rate_average_next  = rate_reg;
                    m_writes_seen_next   = write_total_reg;
                    m_enqueued_seen_next = enqueue_total_reg;
                    m_dequeued_seen_next = dequeue_total_reg;
                    state_next           = qqwm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = qqwm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= qqwm_pkg::ST_IDLE;
            mop_reg             <= qqwm_pkg::M_RES;
            phase_reg           <= qqwm_pkg::PH_ACCRUE;
            local_queued_reg    <= '0;
            high_water_reg      <= '0;
            alert_done_reg      <= 1'b0;
            interval_events_reg <= '0;
            events_interval_reg <= '0;
            average_age_reg     <= 32'd1;
            decayed_avg_reg     <= '0;
            write_total_reg     <= '0;
            enqueue_total_reg   <= '0;
            dequeue_total_reg   <= '0;
            alert_threshold_reg <= '0;
            sample_weight_reg   <= 16'd6554;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg           <= state_next;
            mop_reg             <= mop_next;
            phase_reg           <= phase_next;
            local_queued_reg    <= local_queued_next;
            high_water_reg      <= high_water_next;
            alert_done_reg      <= alert_done_next;
            interval_events_reg <= interval_events_next;
            events_interval_reg <= events_interval_next;
            average_age_reg     <= average_age_next;
            decayed_avg_reg     <= decayed_avg_next;
            write_total_reg     <= write_total_next;
            enqueue_total_reg   <= enqueue_total_next;
            dequeue_total_reg   <= dequeue_total_next;
            alert_threshold_reg <= alert_threshold_next;
            sample_weight_reg   <= sample_weight_next;
            m_valid_reg         <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pow_age_reg         <= pow_age_next;
        res_reg             <= res_next;
        base_reg            <= base_next;
        term_reg            <= term_next;
        blend_reg           <= blend_next;
        rate_reg            <= rate_next;
        new_max_reg         <= new_max_next;
        raise_reg           <= raise_next;
        total_reg           <= total_next;
        req_reg             <= req_next;
        num_reg             <= num_next;
        att_reg             <= att_next;
        unread_reg          <= unread_next;
        now_reg             <= now_next;
        m_total_used_reg    <= m_total_used_next;
        m_new_max_reg       <= m_new_max_next;
        m_alert_reg         <= m_alert_next;
        m_max_used_reg      <= m_max_used_next;
        m_rate_average_reg  <= m_rate_average_next;
        m_writes_seen_reg   <= m_writes_seen_next;
        m_enqueued_seen_reg <= m_enqueued_seen_next;
        m_dequeued_seen_reg <= m_dequeued_seen_next;
    end

    assign s_ready         = (state_reg == qqwm_pkg::ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_total_used    = m_total_used_reg;
    assign m_new_max       = m_new_max_reg;
    assign m_alert         = m_alert_reg;
    assign m_max_used      = m_max_used_reg;
    assign m_rate_average  = m_rate_average_reg;
    assign m_writes_seen   = m_writes_seen_reg;
    assign m_enqueued_seen = m_enqueued_seen_reg;
    assign m_dequeued_seen = m_dequeued_seen_reg;

endmodule

// ----- rtl/qqwm_checker.sv -----
// Port-level checker for the queue quota watermark monitor, bound to the top level.
module qqwm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [23:0] m_total_used,
    input logic        m_new_max,
    input logic        m_alert,
    input logic [23:0] m_max_used,
    input logic [39:0] m_rate_average
);

    // A stalled result must keep its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_used) && $stable(m_max_used))
        else $error("stalled result changed");

    // A new maximum is the high-water mark itself.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_new_max |-> m_total_used == m_max_used)
        else $error("new maximum differs from high-water mark");

    // The rate and the alert come only with a new maximum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_new_max |-> m_rate_average == 40'd0 && !m_alert)
        else $error("rate or alert without a new maximum");

    // Reset drops any pending result.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind queue_quota_watermark_monitor qqwm_checker u_qqwm_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_total_used   (m_total_used),
    .m_new_max      (m_new_max),
    .m_alert        (m_alert),
    .m_max_used     (m_max_used),
    .m_rate_average (m_rate_average)
);
